// ===== sv/fpds_pkg.sv =====
// Package for the flux data separator: shared types, widths and constants.
// Depends on nothing; every module of the block imports it.
package fpds_pkg;

  localparam int TimeBits  = 32;
  localparam int FracBits  = 16;
  localparam int PhaseBits = TimeBits + FracBits;
  localparam int FreqBits  = 40;
  localparam int MulABits  = 64;
  localparam int MulBBits  = 48;
  localparam int DivQBits  = 64;
  localparam int DivSBits  = 48;
  localparam int CntBits   = 7;
  localparam int CfgIdxBits = 8;

  localparam logic [FreqBits-1:0] FreqMax   = '1;
  localparam logic [62:0]         DeltaCap  = 63'h4000_0000_0000_0000;
  localparam logic [2:0]          MaxCells  = 3'd4;

  localparam logic [CfgIdxBits-1:0] RegNomPeriod = 8'd0;
  localparam logic [CfgIdxBits-1:0] RegPhaseGain = 8'd1;
  localparam logic [CfgIdxBits-1:0] RegFreqGain  = 8'd2;
  localparam logic [CfgIdxBits-1:0] RegMaxDrift  = 8'd3;

  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_LDIV, ST_LNOM, ST_LLO, ST_LLOW, ST_LHI, ST_LHIGH,
    ST_PREP, ST_CMUL, ST_CRND, ST_CDIV, ST_CELL, ST_ERR, ST_MAGL, ST_CORR,
    ST_PUPD, ST_M1, ST_M1D, ST_DMUL, ST_DLT, ST_UPD
  } fpds_state_t;

endpackage

// ===== sv/fpds_smul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle while stepped, LSB first.
// Depends on fpds_pkg.
module fpds_smul import fpds_pkg::*; (
  input  logic                clk,
  input  ser_ctl_t            ctl,
  input  logic [MulABits-1:0] a,
  input  logic [MulBBits-1:0] b,
  output logic [MulABits-1:0] hi,
  output logic [MulBBits-1:0] lo
);

  logic [MulABits-1:0] a_r, hi_r;
  logic [MulBBits-1:0] b_r, lo_r;
  logic [MulABits:0]   sum;

  // add the multiplicand into the upper half, then shift one place right
  assign sum = {1'b0, hi_r} + (b_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (ctl.step) begin
      b_r  <= {1'b0, b_r[MulBBits-1:1]};
      hi_r <= sum[MulABits:1];
      lo_r <= {sum[0], lo_r[MulBBits-1:1]};
    end
  end

  assign hi = hi_r;
  assign lo = lo_r;

endmodule

// ===== sv/fpds_sdiv.sv =====
// Restoring divider, one quotient bit per cycle while stepped, dividend streamed MSB first.
// Depends on fpds_pkg.
module fpds_sdiv import fpds_pkg::*; (
  input  logic                clk,
  input  ser_ctl_t            ctl,
  input  logic [FreqBits-1:0] divisor,
  input  logic [DivSBits-1:0] dividend,
  output logic [DivQBits-1:0] quot,
  output logic [FreqBits-1:0] rem
);

  logic [FreqBits-1:0] d_r, r_r;
  logic [DivSBits-1:0] s_r;
  logic [DivQBits-1:0] q_r;
  logic [FreqBits:0]   r2;
  logic                fits;

  assign r2   = {r_r, s_r[DivSBits-1]};
  assign fits = r2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d_r <= divisor;
      s_r <= dividend;
      r_r <= {{(FreqBits-1){1'b0}}, 1'b1};   // leading one of the dividend
      q_r <= '0;
    end else if (ctl.step) begin
      s_r <= {s_r[DivSBits-2:0], 1'b0};
      r_r <= fits ? FreqBits'(r2 - {1'b0, d_r}) : r2[FreqBits-1:0];
      q_r <= {q_r[DivQBits-2:0], fits};
    end
  end

  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== sv/flux_pll_data_separator.sv =====
// Top level of the flux data separator: sequencer, loop state and ports.
// Depends on fpds_pkg, fpds_smul and fpds_sdiv.
//
// Use: each input transaction carries one flux transition timestamp in
// in_tdata (ticks, wrapping) and a restart flag in in_tuser. Each accepted
// transaction yields exactly one output transaction: cell count (1..4, i.e.
// count-1 zeros then a one), the updated loop frequency and a clamp flag.
// Registers are written over the cfg_ channel (always ready); write them
// only while the block is idle. Gains apply at once, period and drift at
// the next restart.
// Each item runs through the sequencer states in turn; a restart first
// reloads the loop. When the transition lies behind the phase, the
// cell-count multiply and its rounding step are skipped. A new item is
// taken only once the last one is through, as the input is taken only in
// the idle state. The cost is set by the shared bit-serial multiplier and
// the divider for the cell length; a restart adds a divider run and two
// multiplies. Reset: load the loop from the reset register values
// (in_tready low meanwhile). A stalled receiver holds the result
// register; the next finished item waits in its last step until the
// register frees, and no new item is taken until then.
module flux_pll_data_separator import fpds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] transition timestamp
  input  logic                  in_tuser,   // [0] restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [2:0] cell_count, [42:3] frequency_now,
                                            // [43] freq_clamped, rest zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [15:0]           cfg_data
);

  fpds_state_t state_r, state_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;

  logic [15:0] nom_period_r, phase_gain_r, freq_gain_r, max_drift_r;

  logic [PhaseBits-1:0] phase_r, tf_r, cell_r, mag_r;
  logic [FreqBits-1:0]  loopf_r, nom_r, low_r, high_r, fv_r;
  logic                 pending_r, neg_r;
  logic [2:0]           cells_r;
  logic [62:0]          delta_r;

  logic                 out_valid_r;
  logic [2:0]           out_cells_r;
  logic [FreqBits-1:0]  out_freq_r;
  logic                 out_clamp_r;

  ser_ctl_t             mul_ctl, div_ctl;
  logic [MulABits-1:0]  mul_a, mul_hi;
  logic [MulBBits-1:0]  mul_b, mul_lo;
  logic [FreqBits-1:0]  div_d, div_rem;
  logic [DivSBits-1:0]  div_s;
  logic [DivQBits-1:0]  div_q;

  logic                 in_acc, out_free;
  logic [FreqBits-1:0]  nom_val, fsel;
  logic [PhaseBits-1:0] dt_val;
  logic [16:0]          drift_lo, drift_hi;

  fpds_smul u_mul (
    .clk (clk), .ctl (mul_ctl), .a (mul_a), .b (mul_b), .hi (mul_hi), .lo (mul_lo)
  );

  fpds_sdiv u_div (
    .clk (clk), .ctl (div_ctl), .divisor (div_d), .dividend (div_s),
    .quot (div_q), .rem (div_rem)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // period 0 or 1 saturates; the quotient holds round(2^48 / period)
  assign nom_val  = (nom_period_r < 16'd2 || (|div_q[PhaseBits-1:FreqBits])) ?
                    FreqMax : div_q[FreqBits-1:0];
  assign fsel     = (loopf_r == '0) ? {{(FreqBits-1){1'b0}}, 1'b1} : loopf_r;
  assign dt_val   = tf_r - phase_r;
  assign drift_lo = 17'h10000 - {1'b0, max_drift_r};
  assign drift_hi = 17'h10000 + {1'b0, max_drift_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  state_nxt = ST_LDIV;
      ST_IDLE:  if (in_acc) state_nxt = in_tuser ? ST_LDIV : ST_PREP;
      ST_LDIV:  if (cnt_r == '0) state_nxt = ST_LNOM;
      ST_LNOM:  state_nxt = ST_LLO;
      ST_LLO:   if (cnt_r == '0) state_nxt = ST_LLOW;
      ST_LLOW:  state_nxt = ST_LHI;
      ST_LHI:   if (cnt_r == '0) state_nxt = ST_LHIGH;
      ST_LHIGH: state_nxt = pending_r ? ST_PREP : ST_IDLE;
      ST_PREP:  state_nxt = dt_val[PhaseBits-1] ? ST_CDIV : ST_CMUL;
      ST_CMUL:  if (cnt_r == '0) state_nxt = ST_CRND;
      ST_CRND:  state_nxt = ST_CDIV;
      ST_CDIV:  if (cnt_r == '0) state_nxt = ST_CELL;
      ST_CELL:  state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_MAGL;
      ST_MAGL:  state_nxt = ST_CORR;
      ST_CORR:  if (cnt_r == '0) state_nxt = ST_PUPD;
      ST_PUPD:  state_nxt = ST_M1;
      ST_M1:    if (cnt_r == '0) state_nxt = ST_M1D;
      ST_M1D:   state_nxt = ST_DMUL;
      ST_DMUL:  if (cnt_r == '0) state_nxt = ST_DLT;
      ST_DLT:   state_nxt = ST_UPD;
      ST_UPD:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_INIT;
    endcase
  end

  // serial unit control and step counter
  always_comb begin
    mul_ctl = '0;
    div_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    div_d   = {24'd0, nom_period_r};
    div_s   = {33'd0, nom_period_r[15:1]};
    cnt_nxt = (cnt_r == '0) ? cnt_r : cnt_r - 1'b1;
    case (state_r)
      ST_INIT: begin
        div_ctl.load = 1'b1;
        cnt_nxt      = CntBits'(47);
      end
      ST_IDLE: begin
        div_ctl.load = in_acc && in_tuser;
        cnt_nxt      = CntBits'(47);
      end
      ST_LDIV, ST_CDIV: div_ctl.step = 1'b1;
      ST_LNOM: begin
        mul_ctl.load = 1'b1;
        mul_a        = MulABits'(nom_val);
        mul_b        = MulBBits'(drift_lo);
        cnt_nxt      = CntBits'(16);
      end
      ST_LLOW: begin
        mul_ctl.load = 1'b1;
        mul_a        = MulABits'(nom_r);
        mul_b        = MulBBits'(drift_hi);
        cnt_nxt      = CntBits'(16);
      end
      ST_LLO, ST_LHI, ST_CMUL, ST_CORR, ST_M1, ST_DMUL: mul_ctl.step = 1'b1;
      ST_PREP: begin
        mul_ctl.load = 1'b1;
        mul_a        = MulABits'(fsel);
        mul_b        = dt_val;
        div_ctl.load = dt_val[PhaseBits-1];
        div_d        = fsel;
        div_s        = '0;
        cnt_nxt      = dt_val[PhaseBits-1] ? CntBits'(63) : CntBits'(47);
      end
      ST_CRND: begin
        div_ctl.load = 1'b1;
        div_d        = fv_r;
        div_s        = '0;
        cnt_nxt      = CntBits'(63);
      end
      ST_MAGL: begin
        mul_ctl.load = 1'b1;
        mul_a        = MulABits'(mag_r);
        mul_b        = MulBBits'(phase_gain_r);
        cnt_nxt      = CntBits'(15);
      end
      ST_PUPD: begin
        mul_ctl.load = 1'b1;
        mul_a        = MulABits'(mag_r);
        mul_b        = MulBBits'(freq_gain_r);
        cnt_nxt      = CntBits'(15);
      end
      ST_M1D: begin
        mul_ctl.load = 1'b1;
        mul_a        = {mul_hi[47:0], mul_lo[47:32]};
        mul_b        = MulBBits'(fv_r);
        cnt_nxt      = CntBits'(39);
      end
      default: ;
    endcase
  end

  // datapath work per step
  logic [2:0]           cells_val;
  logic [PhaseBits-1:0] cell_val, cmul, expected, err, corr;
  logic [73:0]          dsum;
  logic [63:0]          nf_sub, nf_add, nf;
  logic                 under, clamp_lo, clamp_hi;
  logic [FreqBits-1:0]  nf_fin;
  logic [56:0]          lim;

  always_comb begin
    // round half up of the cell estimate, then limit to 1..4
    if (|mul_hi[63:18]) cells_val = MaxCells;
    else                cells_val = 3'({1'b0, mul_hi[17:16]} + {2'b0, mul_hi[15]});
    if (cells_val > MaxCells) cells_val = MaxCells;
    if (cells_val == 3'd0)    cells_val = 3'd1;

    // a frequency of one or less gives a saturated cell length
    cell_val = (fv_r <= {{(FreqBits-1){1'b0}}, 1'b1}) ? '1 :
               div_q[PhaseBits-1:0] +
               PhaseBits'({div_rem, 1'b0} >= {1'b0, fv_r});

    case (cells_r)
      3'd2:    cmul = {cell_r[PhaseBits-2:0], 1'b0};
      3'd3:    cmul = cell_r + {cell_r[PhaseBits-2:0], 1'b0};
      3'd4:    cmul = {cell_r[PhaseBits-3:0], 2'b0};
      default: cmul = cell_r;
    endcase
    expected = phase_r + cmul;
    err      = tf_r - expected;

    corr = mul_hi[PhaseBits-1:0] + PhaseBits'(mul_lo[47]);

    dsum = {1'b0, mul_hi, mul_lo[47:39]} + 74'd1;

    under    = neg_r && ({1'b0, delta_r} > {24'd0, fv_r});
    nf_sub   = {24'd0, fv_r} - {1'b0, delta_r};
    nf_add   = {24'd0, fv_r} + {1'b0, delta_r};
    nf       = neg_r ? nf_sub : nf_add;
    clamp_lo = under || (nf < {24'd0, low_r});
    if (clamp_lo) nf = {24'd0, low_r};
    clamp_hi = nf > {24'd0, high_r};
    if (clamp_hi) nf = {24'd0, high_r};
    nf_fin   = nf[FreqBits-1:0];

    lim = {mul_hi[55:0], mul_lo[47]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      nom_period_r <= 16'd4000;
      phase_gain_r <= 16'd3277;
      freq_gain_r  <= 16'd328;
      max_drift_r  <= 16'd9830;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegNomPeriod: nom_period_r <= cfg_data;
          RegPhaseGain: phase_gain_r <= cfg_data;
          RegFreqGain:  freq_gain_r  <= cfg_data;
          RegMaxDrift:  max_drift_r  <= cfg_data;
          default: ;    // drop writes beyond the register list
        endcase
      end
      if (in_acc) begin
        pending_r <= 1'b1;
      end else if (state_r == ST_UPD && out_free) begin
        pending_r <= 1'b0;
      end
      // load a new result, else drop the one taken by the receiver
      if (state_r == ST_UPD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: tf_r <= {in_tdata, {FracBits{1'b0}}};
      ST_LNOM: begin
        nom_r   <= nom_val;
        loopf_r <= nom_val;
        phase_r <= '0;
      end
      ST_LLOW:  low_r  <= lim[FreqBits-1:0];
      ST_LHIGH: high_r <= (|lim[56:FreqBits]) ? FreqMax : lim[FreqBits-1:0];
      ST_PREP: begin
        fv_r    <= fsel;
        cells_r <= 3'd1;
      end
      ST_CRND:  cells_r <= cells_val;
      ST_CELL:  cell_r  <= cell_val;
      ST_ERR: begin
        neg_r <= err[PhaseBits-1];
        mag_r <= err[PhaseBits-1] ? PhaseBits'(-err) : err;
      end
      ST_PUPD:  phase_r <= neg_r ? tf_r - corr : tf_r + corr;
      ST_DLT:   delta_r <= (dsum[73:1] > {10'd0, DeltaCap}) ? DeltaCap : dsum[63:1];
      ST_UPD: begin
        if (out_free) begin
          loopf_r     <= nf_fin;
          out_cells_r <= cells_r;
          out_freq_r  <= nf_fin;
          out_clamp_r <= clamp_lo || clamp_hi;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_clamp_r, out_freq_r, out_cells_r};

endmodule

// ===== bench/fpds_checker.sv =====
// Checker for the flux data separator: watches the input, result and register
// channels, predicts every result from its own loop model and compares.
// Depends on fpds_pkg for widths and register indexes.
module fpds_checker import fpds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [31:0]           in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [47:0]           out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [15:0]           cfg_data,
  output int                    fail_count,
  output int                    results_waiting,
  output int                    clamp_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]          cells;
    logic [FreqBits-1:0] freq;
    logic                clamped;
  } sep_result_t;

  sep_result_t pending_results[$];

  logic [15:0]          period_r, pgain_r, fgain_r, drift_r;
  logic [PhaseBits-1:0] phase_q;
  logic [FreqBits-1:0]  freq_q, nom_q, low_q, high_q;

  function automatic void reload_loop();
    logic [63:0] nom, hi;
    if (period_r == 0) begin
      nom = 64'(FreqMax);
    end else begin
      nom = ((64'd1 << 48) + 64'(period_r >> 1)) / 64'(period_r);
      if (nom > 64'(FreqMax)) nom = 64'(FreqMax);
    end
    nom_q   = nom[FreqBits-1:0];
    freq_q  = nom[FreqBits-1:0];
    phase_q = '0;
    low_q   = FreqBits'((nom * (64'd65536 - 64'(drift_r))) >> 16);
    hi      = (nom * (64'd65536 + 64'(drift_r))) >> 16;
    high_q  = (hi > 64'(FreqMax)) ? FreqMax : hi[FreqBits-1:0];
  endfunction

  // Advance the loop by one flux transition and return the separated cells.
  function automatic sep_result_t separate_transition(logic restart, logic [31:0] stamp);
    logic [PhaseBits-1:0] tf, dt, target, err, mag, corr;
    logic [63:0]          f, cell_len, delta, nf;
    logic [129:0]         w;
    logic [2:0]           cells;
    logic                 neg, clamped;
    sep_result_t          res;
    if (restart) reload_loop();
    tf = {stamp, 16'h0};
    f  = (freq_q == 0) ? 64'd1 : 64'(freq_q);
    dt = tf - phase_q;
    if (dt[PhaseBits-1]) begin
      cells = 3'd1;
    end else begin
      w = (130'(dt) * 130'(f) + (130'd1 << 63)) >> 64;
      if (w > 130'(MaxCells)) cells = MaxCells;
      else if (w == 0) cells = 3'd1;
      else cells = w[2:0];
    end
    if (f <= 1) begin
      cell_len = '1;
    end else begin
      w = ((130'd1 << 65) + 130'(f)) / (130'(f) << 1);
      cell_len = (w > 130'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : w[63:0];
    end
    target = phase_q + PhaseBits'(64'(cells) * cell_len);
    err    = tf - target;
    neg    = err[PhaseBits-1];
    mag    = neg ? -err : err;
    w      = (130'(mag) * 130'(pgain_r) + 130'd32768) >> 16;
    corr   = w[PhaseBits-1:0];
    phase_q = neg ? tf - corr : tf + corr;
    w     = (130'(mag) * 130'(fgain_r) * 130'(f) + (130'd1 << 31)) >> 32;
    delta = (w > 130'(DeltaCap)) ? 64'(DeltaCap) : w[63:0];
    clamped = 1'b0;
    if (neg && delta > f) begin
      nf = 64'(low_q);
      clamped = 1'b1;
    end else begin
      nf = neg ? f - delta : f + delta;
      if (nf < 64'(low_q)) begin
        nf = 64'(low_q);
        clamped = 1'b1;
      end
    end
    if (nf > 64'(high_q)) begin
      nf = 64'(high_q);
      clamped = 1'b1;
    end
    freq_q = nf[FreqBits-1:0];
    res.cells   = cells;
    res.freq    = freq_q;
    res.clamped = clamped;
    return res;
  endfunction

  always @(posedge clk) begin
    sep_result_t want, got;
    if (!rst_n) begin
      period_r = 16'd4000;
      pgain_r  = 16'd3277;
      fgain_r  = 16'd328;
      drift_r  = 16'd9830;
      reload_loop();
      pending_results.delete();
      fail_count      = 0;
      clamp_count     = 0;
      results_waiting = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegNomPeriod: period_r = cfg_data;
          RegPhaseGain: pgain_r  = cfg_data;
          RegFreqGain:  fgain_r  = cfg_data;
          RegMaxDrift:  drift_r  = cfg_data;
          default: ;  // unknown register: drop the write
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.cells   = out_tdata[2:0];
        got.freq    = out_tdata[42:3];
        got.clamped = out_tdata[43];
        if (pending_results.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("MISMATCH: unexpected result cells=%0d freq=%h clamp=%b",
                     got.cells, got.freq, got.clamped);
        end else begin
          want = pending_results.pop_front();
          if (got.clamped) clamp_count = clamp_count + 1;
          if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("MISMATCH: cells %0d/%0d freq %h/%h clamp %b/%b (exp/act)",
                       want.cells, got.cells, want.freq, got.freq,
                       want.clamped, got.clamped);
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(separate_transition(in_tuser, in_tdata));
      results_waiting = pending_results.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the flux data separator bench: clock, reset, stimulus and verdict.
// Depends on fpds_pkg, the block flux_pll_data_separator and fpds_checker.
module tb_top;
  import fpds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxBits-1:0] RegUnused = 8'd9;
  localparam int PhaseCount  = 10;
  localparam int ItemsPerRun = 130;
  localparam int Settle      = 320;  // worst item latency with restart, plus slack

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0, in_tready;
  logic [31:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid, out_tready = 1'b0;
  logic [47:0]           out_tdata;
  logic                  cfg_valid = 1'b0, cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  int fail_count, results_waiting, clamp_count;
  int items_sent, restarts_sent;
  int burst_left, gap_max;
  bit long_hold_req;
  logic [31:0] stamp;

  always #6 clk = ~clk;

  flux_pll_data_separator u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  fpds_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .results_waiting, .clamp_count
  );

  // Receiver: change its stall mode every so often; one long hold-off on request.
  initial begin
    int mode, mode_left, hold_left;
    bit hold_used;
    mode = 0; mode_left = 0; hold_left = 0; hold_used = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_used) begin
        hold_used = 1;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          default: out_tready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  // Offer one transition; hold it until the block takes it, then maybe idle.
  task automatic send_transition(input logic restart, input logic [31:0] t);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= restart;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (restart) restarts_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pause the sender until every result is back and the block has gone quiet.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_waiting != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  initial begin
    logic [15:0] period, pg, fg, drift;
    int cell_ticks, k, jitter;
    items_sent = 0; restarts_sent = 0; burst_left = 0; gap_max = 6;
    long_hold_req = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, wrap-around, backward steps, saturated counts.
    send_transition(1'b1, 32'd0);
    send_transition(1'b0, 32'd4000);
    send_transition(1'b0, 32'd10000);            // one and a half nominal cells after the last
    send_transition(1'b0, 32'd14000);
    send_transition(1'b0, 32'd13000);            // behind the phase
    send_transition(1'b0, 32'd13000);
    send_transition(1'b0, 32'd900000);           // far gap: count saturates
    send_transition(1'b0, 32'hFFFF_FFFF);        // reads as a large backward jump
    send_transition(1'b1, 32'hFFFF_F000);
    send_transition(1'b0, 32'hFFFF_FFA0);
    send_transition(1'b0, 32'h0000_0F00);        // wraps through zero
    send_transition(1'b0, 32'h0000_2E00);
    send_transition(1'b0, 32'h8000_0000);
    send_transition(1'b0, 32'h8000_0FA0);
    send_transition(1'b1, 32'h5555_5555);
    send_transition(1'b0, 32'hAAAA_AAAA);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain();
      case (ph)
        0: begin period = 4000;  pg = 3277;  fg = 328;   drift = 9830;  end
        1: begin period = 256;   pg = 65535; fg = 65535; drift = 32768; end
        2: begin period = 65535; pg = 0;     fg = 0;     drift = 0;     end
        3: begin period = 0;     pg = 3277;  fg = 328;   drift = 9830;  end
        4: begin period = 2000;  pg = 6000;  fg = 1000;  drift = 4000;  end
        5: begin period = 8000;  pg = 20000; fg = 5000;  drift = 20000; end
        default: begin
          period = 16'($urandom_range(256, 65535));
          pg     = 16'($urandom_range(0, 65535));
          fg     = 16'($urandom_range(0, 65535));
          drift  = 16'($urandom_range(0, 32768));
        end
      endcase
      write_reg(RegNomPeriod, period);
      write_reg(RegPhaseGain, pg);
      write_reg(RegFreqGain, fg);
      write_reg(RegMaxDrift, drift);
      if (ph == 4) write_reg(RegUnused, 16'd300);  // must leave the loop alone
      gap_max = (ph % 3 == 0) ? 0 : 8;
      cell_ticks = (period == 0) ? 256 : int'(period);
      stamp = $urandom();
      send_transition(1'b1, stamp);
      for (int n = 1; n < ItemsPerRun; n++) begin
        if (ph == 1 && n == 40) long_hold_req = 1;
        k = $urandom_range(0, 99);
        if (k < 8) begin
          stamp = $urandom();                      // noise
        end else if (k < 11) begin
          stamp = stamp - $urandom_range(1, 3 * cell_ticks);
        end else begin
          jitter = $urandom_range(0, cell_ticks / 2) - cell_ticks / 4;
          stamp = stamp + $urandom_range(1, 5) * cell_ticks + jitter;
        end
        send_transition($urandom_range(0, 99) < 3, stamp);
      end
    end

    drain();
    $display("Covered %0d transitions (%0d restarts) over %0d register settings,",
             items_sent, restarts_sent, PhaseCount + 1);
    $display("including %0d frequency clamps and a long receiver hold-off.", clamp_count);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout with %0d results outstanding", results_waiting);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fpds_pkg.sv
sv/fpds_smul.sv
sv/fpds_sdiv.sv
sv/flux_pll_data_separator.sv
bench/fpds_checker.sv
bench/tb_top.sv
